[sv/tpmrb_pkg.sv]
// Package for the TCP payload match and reset builder.
// Holds the port word types, register indexes, the redirect text and the checksum fold.
// No dependencies.
package tpmrb_pkg;

  localparam int PatternBytesDefault = 16;
  localparam int QueueDepth          = 2;
  localparam int RedirectLen         = 57;

  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        block;
    logic [31:0] client_ip;
    logic [31:0] server_ip;
    logic [15:0] client_port;
    logic [15:0] server_port;
    logic [31:0] next_sequence;
    logic [31:0] peer_acknowledge;
    logic [15:0] reset_ip_checksum;
    logic [15:0] reset_tcp_checksum;
    logic [15:0] finish_ip_checksum;
    logic [15:0] finish_tcp_checksum;
  } out_word_t;

  typedef struct packed {
    logic [4:0]  pattern_length;
    logic [63:0] pattern_low_word;
    logic [63:0] pattern_high_word;
  } cfg_t;

  // Per-frame summary handed from the parser to the checksum builder.
  typedef struct packed {
    logic        block;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] total_len;
    logic [5:0]  ip_hdr_len;
    logic [5:0]  tcp_hdr_len;
  } frame_sum_t;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'h06;
  localparam logic [31:0] IpFixedSum    = 32'h0000_C506;
  localparam logic [31:0] RstIpLen      = 32'd40;
  localparam logic [31:0] FinIpLen      = 32'd97;
  localparam logic [31:0] TcpProto      = 32'h0000_0006;
  localparam logic [31:0] RstTcpLen     = 32'd20;
  localparam logic [31:0] FinTcpLen     = 32'd77;
  localparam logic [31:0] RstFlags      = 32'h0000_5014;
  localparam logic [31:0] FinFlags      = 32'h0000_5011;
  localparam logic [31:0] FinWindow     = 32'h0000_FFFF;

  localparam logic [7:0] RedirectText [RedirectLen] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30, 8'h20, 8'h33,
    8'h30, 8'h32, 8'h20, 8'h52, 8'h65, 8'h64, 8'h69, 8'h72, 8'h65, 8'h63,
    8'h74, 8'h0D, 8'h0A, 8'h4C, 8'h6F, 8'h63, 8'h61, 8'h74, 8'h69, 8'h6F,
    8'h6E, 8'h3A, 8'h20, 8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F,
    8'h77, 8'h61, 8'h72, 8'h6E, 8'h69, 8'h6E, 8'h67, 8'h2E, 8'h6F, 8'h72,
    8'h2E, 8'h6B, 8'h72, 8'h0D, 8'h0A, 8'h0D, 8'h0A
  };

  function automatic logic [31:0] redirect_sum();
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < RedirectLen; i++) begin
      if (i % 2 == 1) s = s + 32'(RedirectText[i]);
      else            s = s + {16'd0, RedirectText[i], 8'd0};
    end
    return s;
  endfunction

  localparam logic [31:0] RedirectSum = redirect_sum();

  // One's complement fold of a 32-bit sum, then invert.
  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    logic [16:0] s3;
    s1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    s3 = {1'b0, s2[15:0]} + {16'd0, s2[16]};
    return ~s3[15:0];
  endfunction

endpackage

[sv/tcp_payload_match_reset_builder_top.sv]
// TCP payload match and reset builder, top level.
// Depends on tpmrb_pkg, tpmrb_front, tpmrb_fifo and tpmrb_back.
//
// Takes an Ethernet frame one byte per cycle (push/full) and, on the frame's
// last byte, produces one result word (empty/pop) holding the block decision
// and the fields and internet checksums of the forged RST+ACK and FIN+ACK
// packets. The parser accepts one byte every cycle; full rises only while the
// two-entry summary queue is full, which happens only when result words are
// not being popped. A result word reaches the result ports after its last byte
// is accepted: the summary queue is written at that edge, and the word then
// passes through the two checksum stages and the two-entry result queue, in
// that order. Pattern registers are written through the cfg port, which is
// always ready; write them only while no frame is in flight.
module tcp_payload_match_reset_builder_top #(
  parameter int PATTERN_BYTES = tpmrb_pkg::PatternBytesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  tpmrb_pkg::in_word_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output tpmrb_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  localparam int SumW = $bits(tpmrb_pkg::frame_sum_t);
  localparam int OutW = $bits(tpmrb_pkg::out_word_t);

  tpmrb_pkg::cfg_t       cfg;
  tpmrb_pkg::frame_sum_t sum_in, sum_out;
  tpmrb_pkg::out_word_t  res_word;
  logic take, sum_push, mid_full, mid_empty, sum_take, res_push, res_full;

  assign cfg_ready = 1'b1;
  // Stall input bytes only when the summary queue has no room.
  assign full = mid_full;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length    <= 5'd1;
      cfg.pattern_low_word  <= '0;
      cfg.pattern_high_word <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (tpmrb_pkg::reg_index_t'(cfg_index))
        tpmrb_pkg::REG_PATTERN_LENGTH: cfg.pattern_length    <= cfg_data[4:0];
        tpmrb_pkg::REG_PATTERN_LOW:    cfg.pattern_low_word  <= cfg_data;
        tpmrb_pkg::REG_PATTERN_HIGH:   cfg.pattern_high_word <= cfg_data;
        default: ;
      endcase
    end
  end

  tpmrb_front #(.PATTERN_BYTES(PATTERN_BYTES)) u_front (
    .clk(clk), .rst(rst), .take(take), .in_word(in_data), .cfg(cfg),
    .sum_push(sum_push), .sum_word(sum_in)
  );

  tpmrb_fifo #(.WIDTH(SumW), .DEPTH(tpmrb_pkg::QueueDepth)) u_mid_q (
    .clk(clk), .rst(rst), .push(sum_push), .full(mid_full), .wdata(sum_in),
    .pop(sum_take), .empty(mid_empty), .rdata(sum_out)
  );

  tpmrb_back u_back (
    .clk(clk), .rst(rst), .sum_valid(!mid_empty), .sum_word(sum_out),
    .sum_take(sum_take), .res_push(res_push), .res_full(res_full),
    .res_word(res_word)
  );

  tpmrb_fifo #(.WIDTH(OutW), .DEPTH(tpmrb_pkg::QueueDepth)) u_out_q (
    .clk(clk), .rst(rst), .push(res_push), .full(res_full), .wdata(res_word),
    .pop(pop), .empty(empty), .rdata(out_data)
  );

  // A frame summary must never be dropped at the summary queue.
  a_mid_no_drop: assert property (@(posedge clk) disable iff (rst)
    sum_push |-> !mid_full) else $error("summary pushed into full queue");

  // The checksum pipe only offers a word when the result queue has room.
  a_res_no_drop: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full) else $error("result pushed into full queue");

  // The checksum pipe only pulls a summary that is present.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    sum_take |-> !mid_empty) else $error("summary taken from empty queue");
endmodule

[sv/tpmrb_fifo.sv]
// Small register queue with push/full and pop/empty sides.
// Generic in width and depth; no package dependency.
module tpmrb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end
endmodule

[sv/tpmrb_front.sv]
// Frame parser: captures header fields, slides the payload window, matches the pattern.
// Depends on tpmrb_pkg; emits one frame_sum_t per frame on the last byte.
module tpmrb_front #(
  parameter int PATTERN_BYTES = tpmrb_pkg::PatternBytesDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  tpmrb_pkg::in_word_t   in_word,
  input  tpmrb_pkg::cfg_t       cfg,
  output logic                  sum_push,
  output tpmrb_pkg::frame_sum_t sum_word
);
  logic [15:0] byte_offset;
  logic [15:0] ether_type, ether_type_next;
  logic [5:0]  ip_hdr, ip_hdr_next;
  logic [7:0]  ip_proto, ip_proto_next;
  logic [15:0] total_len, total_len_next;
  logic [31:0] src_addr, src_addr_next;
  logic [31:0] dst_addr, dst_addr_next;
  logic [15:0] tcp_sport, tcp_sport_next;
  logic [15:0] tcp_dport, tcp_dport_next;
  logic [31:0] seq_num, seq_num_next;
  logic [31:0] ack_num, ack_num_next;
  logic [5:0]  tcp_hdr, tcp_hdr_next;
  logic [7:0]  window [PATTERN_BYTES];
  logic [7:0]  window_next [PATTERN_BYTES];
  logic        match_seen, match_seen_next;

  logic [7:0]  b;
  logic [7:0]  pat [16];
  logic [4:0]  len;
  logic [6:0]  tcp_start;
  logic [15:0] rel;
  logic        hdr_ok;
  logic [7:0]  pay_start;
  logic [16:0] pay_end;
  logic        in_payload;
  logic        eq;
  logic [4:0]  pidx;

  assign b = in_word.frame_byte;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pat[k]     = cfg.pattern_low_word[8*k +: 8];
      pat[k + 8] = cfg.pattern_high_word[8*k +: 8];
    end
    len = cfg.pattern_length;
    if (len == 5'd0) len = 5'd1;
    if (len > 5'(PATTERN_BYTES)) len = 5'(PATTERN_BYTES);
  end

  always_comb begin
    ether_type_next = ether_type;
    ip_hdr_next     = ip_hdr;
    ip_proto_next   = ip_proto;
    total_len_next  = total_len;
    src_addr_next   = src_addr;
    dst_addr_next   = dst_addr;
    tcp_sport_next  = tcp_sport;
    tcp_dport_next  = tcp_dport;
    seq_num_next    = seq_num;
    ack_num_next    = ack_num;
    tcp_hdr_next    = tcp_hdr;
    window_next     = window;
    match_seen_next = match_seen;
    eq              = 1'b1;
    pidx            = '0;
    rel             = '0;

    if (byte_offset == 16'd12) ether_type_next = {b, 8'd0};
    else if (byte_offset == 16'd13) ether_type_next = {ether_type[15:8], b};
    else if (byte_offset == 16'd14) ip_hdr_next = {b[3:0], 2'b00};
    else if (byte_offset == 16'd16) total_len_next = {b, 8'd0};
    else if (byte_offset == 16'd17) total_len_next = {total_len[15:8], b};
    else if (byte_offset == 16'd23) ip_proto_next = b;
    else if (byte_offset >= 16'd26 && byte_offset <= 16'd29) src_addr_next = {src_addr[23:0], b};
    else if (byte_offset >= 16'd30 && byte_offset <= 16'd33) dst_addr_next = {dst_addr[23:0], b};

    tcp_start = 7'd14 + 7'(ip_hdr_next);
    if (byte_offset >= 16'd15 && byte_offset >= 16'(tcp_start)) begin
      rel = byte_offset - 16'(tcp_start);
      if (rel <= 16'd1) tcp_sport_next = {tcp_sport[7:0], b};
      else if (rel <= 16'd3) tcp_dport_next = {tcp_dport[7:0], b};
      else if (rel <= 16'd7) seq_num_next = {seq_num[23:0], b};
      else if (rel <= 16'd11) ack_num_next = {ack_num[23:0], b};
      else if (rel == 16'd12) tcp_hdr_next = {b[7:4], 2'b00};
    end

    hdr_ok     = (ip_hdr_next >= 6'd20) && (tcp_hdr_next >= 6'd20);
    pay_start  = 8'(tcp_start) + 8'(tcp_hdr_next);
    pay_end    = 17'(total_len_next) + 17'd14;
    in_payload = hdr_ok && (byte_offset >= 16'(pay_start))
                 && ({1'b0, byte_offset} < pay_end);

    if (in_payload) begin
      for (int j = PATTERN_BYTES - 1; j > 0; j--) window_next[j] = window[j - 1];
      window_next[0] = b;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
        if (5'(j) < len) begin
          pidx = len - 5'd1 - 5'(j);
          if (window_next[j] != pat[pidx[3:0]]) eq = 1'b0;
        end
      end
      if (({1'b0, byte_offset} + 17'd1 >= 17'(pay_start) + 17'(len)) && eq)
        match_seen_next = 1'b1;
    end
  end

  always_comb begin
    sum_push             = take && in_word.last_byte;
    sum_word.block       = (ether_type_next == tpmrb_pkg::EtherTypeIpv4)
                           && (ip_proto_next == tpmrb_pkg::ProtoTcp) && hdr_ok
                           && (pay_end <= 17'd65535)
                           && ({1'b0, byte_offset} + 17'd1 >= pay_end)
                           && (17'(total_len_next) >= 17'(ip_hdr_next) + 17'(tcp_hdr_next)
                               + 17'(len))
                           && match_seen_next;
    sum_word.src_addr    = src_addr_next;
    sum_word.dst_addr    = dst_addr_next;
    sum_word.tcp_sport   = tcp_sport_next;
    sum_word.tcp_dport   = tcp_dport_next;
    sum_word.seq_num     = seq_num_next;
    sum_word.ack_num     = ack_num_next;
    sum_word.total_len   = total_len_next;
    sum_word.ip_hdr_len  = ip_hdr_next;
    sum_word.tcp_hdr_len = tcp_hdr_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && in_word.last_byte)) begin
      byte_offset <= '0;
      ether_type  <= '0;
      ip_hdr      <= '0;
      ip_proto    <= '0;
      total_len   <= '0;
      src_addr    <= '0;
      dst_addr    <= '0;
      tcp_sport   <= '0;
      tcp_dport   <= '0;
      seq_num     <= '0;
      ack_num     <= '0;
      tcp_hdr     <= '0;
      match_seen  <= 1'b0;
      for (int j = 0; j < PATTERN_BYTES; j++) window[j] <= '0;
    end else if (take) begin
      if (byte_offset != 16'hFFFF) byte_offset <= byte_offset + 16'd1;
      ether_type <= ether_type_next;
      ip_hdr     <= ip_hdr_next;
      ip_proto   <= ip_proto_next;
      total_len  <= total_len_next;
      src_addr   <= src_addr_next;
      dst_addr   <= dst_addr_next;
      tcp_sport  <= tcp_sport_next;
      tcp_dport  <= tcp_dport_next;
      seq_num    <= seq_num_next;
      ack_num    <= ack_num_next;
      tcp_hdr    <= tcp_hdr_next;
      match_seen <= match_seen_next;
      window     <= window_next;
    end
  end
endmodule

[sv/tpmrb_back.sv]
// Checksum builder: two register stages from frame summary to result word.
// Depends on tpmrb_pkg; feeds the output queue through push/full.
module tpmrb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sum_valid,
  input  tpmrb_pkg::frame_sum_t sum_word,
  output logic                  sum_take,
  output logic                  res_push,
  input  logic                  res_full,
  output tpmrb_pkg::out_word_t  res_word
);
  typedef struct packed {
    logic        block;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [31:0] next_seq;
    logic [31:0] ack_num;
    logic [31:0] addr_sum;
    logic [31:0] port_sum;
    logic [31:0] ack_sum;
  } st1_t;

  typedef struct packed {
    logic        block;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [31:0] next_seq;
    logic [31:0] ack_num;
    logic [31:0] rst_ip;
    logic [31:0] rst_tcp;
    logic [31:0] fin_ip;
    logic [31:0] fin_tcp;
  } st2_t;

  logic v1, v2;
  st1_t s1, s1_next;
  st2_t s2, s2_next;
  logic advance;
  logic [31:0] seq_sum;

  // Hold the pipe while the finished word cannot enter the output queue.
  assign advance  = !(v2 && res_full);
  assign sum_take = advance && sum_valid;
  assign res_push = v2 && !res_full;

  always_comb begin
    s1_next.block     = sum_word.block;
    s1_next.src_addr  = sum_word.src_addr;
    s1_next.dst_addr  = sum_word.dst_addr;
    s1_next.tcp_sport = sum_word.tcp_sport;
    s1_next.tcp_dport = sum_word.tcp_dport;
    s1_next.ack_num   = sum_word.ack_num;
    s1_next.next_seq  = sum_word.seq_num + 32'(sum_word.total_len)
                        - 32'(sum_word.ip_hdr_len) - 32'(sum_word.tcp_hdr_len);
    s1_next.addr_sum  = 32'(sum_word.src_addr[31:16]) + 32'(sum_word.src_addr[15:0])
                        + 32'(sum_word.dst_addr[31:16]) + 32'(sum_word.dst_addr[15:0]);
    s1_next.port_sum  = 32'(sum_word.tcp_sport) + 32'(sum_word.tcp_dport);
    s1_next.ack_sum   = 32'(sum_word.ack_num[31:16]) + 32'(sum_word.ack_num[15:0]);
  end

  always_comb begin
    seq_sum           = 32'(s1.next_seq[31:16]) + 32'(s1.next_seq[15:0]);
    s2_next.block     = s1.block;
    s2_next.src_addr  = s1.src_addr;
    s2_next.dst_addr  = s1.dst_addr;
    s2_next.tcp_sport = s1.tcp_sport;
    s2_next.tcp_dport = s1.tcp_dport;
    s2_next.next_seq  = s1.next_seq;
    s2_next.ack_num   = s1.ack_num;
    s2_next.rst_ip    = tpmrb_pkg::IpFixedSum + tpmrb_pkg::RstIpLen + s1.addr_sum;
    s2_next.fin_ip    = tpmrb_pkg::IpFixedSum + tpmrb_pkg::FinIpLen + s1.addr_sum;
    s2_next.rst_tcp   = s1.addr_sum + tpmrb_pkg::TcpProto + tpmrb_pkg::RstTcpLen
                        + s1.port_sum + seq_sum + s1.ack_sum + tpmrb_pkg::RstFlags;
    s2_next.fin_tcp   = s1.addr_sum + tpmrb_pkg::TcpProto + tpmrb_pkg::FinTcpLen
                        + s1.port_sum + seq_sum + s1.ack_sum + tpmrb_pkg::FinFlags
                        + tpmrb_pkg::FinWindow + tpmrb_pkg::RedirectSum;
  end

  always_comb begin
    res_word.block               = s2.block;
    res_word.client_ip           = s2.src_addr;
    res_word.server_ip           = s2.dst_addr;
    res_word.client_port         = s2.tcp_sport;
    res_word.server_port         = s2.tcp_dport;
    res_word.next_sequence       = s2.next_seq;
    res_word.peer_acknowledge    = s2.ack_num;
    res_word.reset_ip_checksum   = tpmrb_pkg::fold16(s2.rst_ip);
    res_word.reset_tcp_checksum  = tpmrb_pkg::fold16(s2.rst_tcp);
    res_word.finish_ip_checksum  = tpmrb_pkg::fold16(s2.fin_ip);
    res_word.finish_tcp_checksum = tpmrb_pkg::fold16(s2.fin_tcp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v1 <= sum_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= s1_next;
      s2 <= s2_next;
    end
  end
endmodule
